FILE: hw/rtl/rc4_pkg.sv
package rc4_pkg;

  // Permutation geometry: one byte per entry, 256 entries.
  localparam int unsigned PermDepth = 256;
  localparam int unsigned PermAw    = 8;

  // Input kind field.
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // Status field of a status beat.
  localparam logic STATUS_ACCEPT = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Operation handed from the front end to the engine.
  typedef enum logic [1:0] {
    OP_DATA,
    OP_KEY,
    OP_KEY_LAST
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] value;
  } op_t;

endpackage

FILE: hw/rtl/rc4_if.sv
interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;
  logic       last_key_byte;

  modport source (output valid, kind, byte_value, last_key_byte, input ready);
  modport sink   (input valid, kind, byte_value, last_key_byte, output ready);
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic       is_status;
  logic [7:0] out_byte;
  logic       status;

  modport source (output valid, is_status, out_byte, status, input ready);
  modport sink   (input valid, is_status, out_byte, status, output ready);
endinterface

FILE: hw/rtl/rc4_front.sv
module rc4_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  rc4_in_if.sink         in_i,
  output logic           op_vld_o,
  output rc4_pkg::op_t   op_o,
  input  logic           op_rdy_i
);
  import rc4_pkg::*;

  // Two-entry queue between the input port and the engine.
  op_t        queue_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  op_t        op_in;
  logic       push, pop;

  always_comb begin
    if (in_i.kind == KIND_DATA) begin
      op_in.op = OP_DATA;
    end else if (in_i.last_key_byte) begin
      op_in.op = OP_KEY_LAST;
    end else begin
      op_in.op = OP_KEY;
    end
    op_in.value = in_i.byte_value;
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign op_vld_o   = (cnt_q != 2'd0);
  assign pop        = op_vld_o && op_rdy_i;
  assign op_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= op_in;
    end
  end

endmodule

FILE: hw/rtl/rc4_back.sv
module rc4_back #(
  parameter int unsigned KEY_MAX_BYTES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_vld_i,
  input  rc4_pkg::op_t   op_i,
  output logic           op_rdy_o,
  rc4_out_if.source      out_o
);
  import rc4_pkg::*;

  localparam int unsigned KeyAw = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam int unsigned CntW  = $clog2(KEY_MAX_BYTES + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_D_J   = 4'd1;
  localparam logic [3:0] ST_D_SWP = 4'd2;
  localparam logic [3:0] ST_D_OUT = 4'd3;
  localparam logic [3:0] ST_K_RD  = 4'd4;
  localparam logic [3:0] ST_K_SUM = 4'd5;
  localparam logic [3:0] ST_K_WRN = 4'd6;
  localparam logic [3:0] ST_K_WRJ = 4'd7;
  localparam logic [3:0] ST_STAT  = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [7:0]        i_q, i_d, j_q, j_d, n_q, n_d;
  logic [7:0]        si_q, si_d, sj_q, sj_d, t_q, t_d, dat_q, dat_d;
  logic [7:0]        key0_q, key0_d;
  logic [KeyAw-1:0]  kpos_q, kpos_d;
  logic [CntW-1:0]   cnt_q, cnt_d, len_q, len_d;
  logic              stat_q, stat_d;

  // Permutation memory with one valid bit per entry; an invalid entry reads as its index.
  logic [7:0]           perm_mem [PermDepth];
  logic [PermDepth-1:0] perm_vld_q;
  logic [7:0]           pdat_q, pra_q;
  logic                 pv_q;
  logic                 p_re, p_we, p_clr;
  logic [PermAw-1:0]    p_ra, p_wa;
  logic [7:0]           p_wd;
  logic [7:0]           perm_rd;

  // Key store.
  logic [7:0]       key_mem [KEY_MAX_BYTES];
  logic [7:0]       kdat_q;
  logic             k_we, k_re;
  logic [KeyAw-1:0] k_wa;

  // Output register.
  logic       out_vld_q;
  logic       out_is_status_q, out_status_q;
  logic [7:0] out_byte_q;
  logic       o_ld, o_is_status, o_status;
  logic [7:0] o_byte;
  logic       out_free;

  logic       room;
  logic [7:0] first_byte, ks, sum_t, sum_j;

  assign perm_rd  = pv_q ? pdat_q : pra_q;
  assign out_free = !out_vld_q || out_o.ready;
  assign room     = (cnt_q < CntW'(KEY_MAX_BYTES));

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    n_d     = n_q;
    si_d    = si_q;
    sj_d    = sj_q;
    t_d     = t_q;
    dat_d   = dat_q;
    key0_d  = key0_q;
    kpos_d  = kpos_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    stat_d  = stat_q;
    op_rdy_o    = 1'b0;
    p_re        = 1'b0;
    p_ra        = '0;
    p_we        = 1'b0;
    p_wa        = '0;
    p_wd        = '0;
    p_clr       = 1'b0;
    k_we        = 1'b0;
    k_re        = 1'b0;
    k_wa        = cnt_q[KeyAw-1:0];
    o_ld        = 1'b0;
    o_is_status = 1'b0;
    o_byte      = '0;
    o_status    = STATUS_ACCEPT;
    first_byte  = (cnt_q == '0) ? op_i.value : key0_q;
    sum_t       = si_q + perm_rd;
    sum_j       = j_q + kdat_q + perm_rd;
    if (t_q == j_q) begin
      ks = si_q;
    end else if (t_q == i_q) begin
      ks = sj_q;
    end else begin
      ks = perm_rd;
    end

    case (state_q)
      ST_IDLE: begin
        op_rdy_o = 1'b1;
        if (op_vld_i) begin
          case (op_i.op)
            OP_DATA: begin
              i_d     = i_q + 8'd1;
              dat_d   = op_i.value;
              p_re    = 1'b1;
              p_ra    = i_q + 8'd1;
              state_d = ST_D_J;
            end
            OP_KEY, OP_KEY_LAST: begin
              if (room) begin
                k_we  = 1'b1;
                cnt_d = cnt_q + CntW'(1);
                if (cnt_q == '0) begin
                  key0_d = op_i.value;
                end
              end
              if (op_i.op == OP_KEY_LAST) begin
                cnt_d = '0;
                if (first_byte == 8'd0) begin
                  stat_d  = STATUS_REJECT;
                  state_d = ST_STAT;
                end else begin
                  len_d   = room ? cnt_q + CntW'(1) : cnt_q;
                  stat_d  = STATUS_ACCEPT;
                  p_clr   = 1'b1;
                  i_d     = '0;
                  j_d     = '0;
                  n_d     = '0;
                  kpos_d  = '0;
                  state_d = ST_K_RD;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_D_J: begin
        si_d    = perm_rd;
        j_d     = j_q + perm_rd;
        p_re    = 1'b1;
        p_ra    = j_q + perm_rd;
        state_d = ST_D_SWP;
      end
      ST_D_SWP: begin
        sj_d    = perm_rd;
        p_we    = 1'b1;
        p_wa    = i_q;
        p_wd    = perm_rd;
        p_re    = 1'b1;
        p_ra    = sum_t;
        t_d     = sum_t;
        state_d = ST_D_OUT;
      end
      ST_D_OUT: begin
        p_we = 1'b1;
        p_wa = j_q;
        p_wd = si_q;
        if (out_free) begin
          o_ld    = 1'b1;
          o_byte  = dat_q ^ ks;
          state_d = ST_IDLE;
        end
      end
      ST_K_RD: begin
        p_re    = 1'b1;
        p_ra    = n_q;
        k_re    = 1'b1;
        state_d = ST_K_SUM;
      end
      ST_K_SUM: begin
        si_d    = perm_rd;
        j_d     = sum_j;
        p_re    = 1'b1;
        p_ra    = sum_j;
        state_d = ST_K_WRN;
      end
      ST_K_WRN: begin
        p_we    = 1'b1;
        p_wa    = n_q;
        p_wd    = perm_rd;
        state_d = ST_K_WRJ;
      end
      ST_K_WRJ: begin
        p_we = 1'b1;
        p_wa = j_q;
        p_wd = si_q;
        n_d  = n_q + 8'd1;
        if (CntW'(kpos_q) + CntW'(1) == len_q) begin
          kpos_d = '0;
        end else begin
          kpos_d = kpos_q + KeyAw'(1);
        end
        if (n_q == 8'hFF) begin
          j_d     = '0;
          state_d = ST_STAT;
        end else begin
          state_d = ST_K_RD;
        end
      end
      ST_STAT: begin
        if (out_free) begin
          o_ld        = 1'b1;
          o_is_status = 1'b1;
          o_status    = stat_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      i_q        <= '0;
      j_q        <= '0;
      cnt_q      <= '0;
      perm_vld_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      cnt_q   <= cnt_d;
      if (p_clr) begin
        perm_vld_q <= '0;
      end else if (p_we) begin
        perm_vld_q[p_wa] <= 1'b1;
      end
      if (o_ld) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    si_q   <= si_d;
    sj_q   <= sj_d;
    t_q    <= t_d;
    dat_q  <= dat_d;
    key0_q <= key0_d;
    kpos_q <= kpos_d;
    len_q  <= len_d;
    stat_q <= stat_d;
    if (o_ld) begin
      out_is_status_q <= o_is_status;
      out_byte_q      <= o_byte;
      out_status_q    <= o_status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      perm_mem[p_wa] <= p_wd;
    end
    if (p_re) begin
      pdat_q <= perm_mem[p_ra];
      pv_q   <= perm_vld_q[p_ra];
      pra_q  <= p_ra;
    end
  end

  always_ff @(posedge clk_i) begin
    if (k_we) begin
      key_mem[k_wa] <= op_i.value;
    end
    if (k_re) begin
      kdat_q <= key_mem[kpos_q];
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.is_status = out_is_status_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.status    = out_status_q;

endmodule

FILE: hw/rtl/rc4_stream_cipher.sv
// Data beat: the engine steps through ST_D_J, ST_D_SWP and ST_D_OUT, then loads the result beat.
// The engine takes no new beat until the current data beat has been loaded as a result.
// Key beat: stored in the idle state; the last key beat of an accepted key adds the key schedule.
// Reset: asynchronous, active low; indices and key count clear, and the permutation
// reads as identity at once through per-entry valid bits, with no clearing pass.
module rc4_stream_cipher #(
  parameter int unsigned KEY_MAX_BYTES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rc4_in_if.sink     in_i,
  rc4_out_if.source  out_o
);
  import rc4_pkg::*;

  // The front end classifies each input beat into a key byte, a closing key
  // byte or a data byte and parks it in a two-entry queue. That queue lets the
  // input side keep taking beats while the engine is busy or while a result
  // beat waits in the output register.
  logic op_vld;
  logic op_rdy;
  op_t  op;

  rc4_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .op_vld_o (op_vld),
    .op_o     (op),
    .op_rdy_i (op_rdy)
  );

  // The engine owns the permutation and the key store. A data byte walks
  // through reads at i and j, the swap and the keystream read; a closing key
  // byte either rejects the key (first byte zero) or runs the 256-step key
  // schedule. Every result beat goes through one output register, so the
  // engine stalls only when that register is still full.
  rc4_back #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_vld_i (op_vld),
    .op_i     (op),
    .op_rdy_o (op_rdy),
    .out_o    (out_o)
  );

endmodule

FILE: bench/rc4_keystream_checker.sv
module rc4_keystream_checker #(
  parameter int unsigned KEY_MAX_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rc4_in_if           in_mon,
  rc4_out_if          out_mon,
  output int unsigned pending_o,
  output int unsigned mismatches_o,
  output int unsigned cipher_beats_o,
  output int unsigned keys_accepted_o,
  output int unsigned keys_rejected_o
);
  import rc4_pkg::*;

  typedef struct packed {
    logic       is_status;
    logic [7:0] out_byte;
    logic       status;
  } cipher_result_t;

  logic [7:0]     sbox [PermDepth];
  logic [7:0]     key_bytes [PermDepth];
  logic [8:0]     key_len;
  logic [7:0]     idx_i;
  logic [7:0]     idx_j;
  cipher_result_t expected_q [$];
  int unsigned    mismatch_cnt = 0;
  int unsigned    cipher_cnt = 0;
  int unsigned    accept_cnt = 0;
  int unsigned    reject_cnt = 0;

  assign mismatches_o    = mismatch_cnt;
  assign cipher_beats_o  = cipher_cnt;
  assign keys_accepted_o = accept_cnt;
  assign keys_rejected_o = reject_cnt;

  function automatic void load_identity();
    for (int unsigned k = 0; k < PermDepth; k++) begin
      sbox[k] = 8'(k);
    end
    idx_i = '0;
    idx_j = '0;
  endfunction

  // Key schedule over the bytes collected for the current key.
  function automatic void run_key_schedule();
    logic [7:0]  jj;
    logic [7:0]  tmp;
    int unsigned kpos;
    load_identity();
    jj   = '0;
    kpos = 0;
    for (int unsigned n = 0; n < PermDepth; n++) begin
      jj       = jj + key_bytes[kpos] + sbox[n];
      tmp      = sbox[n];
      sbox[n]  = sbox[jj];
      sbox[jj] = tmp;
      kpos     = (kpos + 1) % key_len;
    end
  endfunction

  function automatic cipher_result_t next_cipher(logic [7:0] data);
    logic [7:0]     tmp;
    logic [7:0]     ks_index;
    cipher_result_t r;
    idx_i       = idx_i + 8'd1;
    idx_j       = idx_j + sbox[idx_i];
    tmp         = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = tmp;
    ks_index    = sbox[idx_i] + sbox[idx_j];
    r.is_status = 1'b0;
    r.out_byte  = data ^ sbox[ks_index];
    r.status    = STATUS_ACCEPT;
    return r;
  endfunction

  function automatic void predict_beat(logic kind, logic [7:0] value, logic mark_last);
    cipher_result_t r;
    if (kind == KIND_DATA) begin
      expected_q.push_back(next_cipher(value));
      return;
    end
    // Bytes past the key limit are dropped, but a last mark still closes the key.
    if (key_len < KEY_MAX_BYTES) begin
      key_bytes[key_len[7:0]] = value;
      key_len++;
    end
    if (mark_last) begin
      r.is_status = 1'b1;
      r.out_byte  = '0;
      if (key_len == 0 || key_bytes[0] == 8'h00) begin
        r.status = STATUS_REJECT;
        reject_cnt++;
      end else begin
        run_key_schedule();
        r.status = STATUS_ACCEPT;
        accept_cnt++;
      end
      key_len = '0;
      expected_q.push_back(r);
    end
  endfunction

  function automatic void check_result(cipher_result_t got);
    cipher_result_t want;
    if (expected_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("%0t: unexpected result beat is_status=%0b out_byte=%02h status=%0b",
                 $realtime, got.is_status, got.out_byte, got.status);
      end
      return;
    end
    want = expected_q.pop_front();
    if (!want.is_status) begin
      cipher_cnt++;
    end
    if (got.is_status !== want.is_status || got.out_byte !== want.out_byte ||
        got.status !== want.status) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("%0t: result mismatch, expected is_status=%0b out_byte=%02h status=%0b",
                 $realtime, want.is_status, want.out_byte, want.status);
        $display("%0t:                  got      is_status=%0b out_byte=%02h status=%0b",
                 $realtime, got.is_status, got.out_byte, got.status);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_identity();
      key_len = '0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        check_result(cipher_result_t'({out_mon.is_status, out_mon.out_byte, out_mon.status}));
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_beat(in_mon.kind, in_mon.byte_value, in_mon.last_key_byte);
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
module tb_top;
  import rc4_pkg::*;

  // The block is built with the full key store, so keys of up to 256 bytes are kept.
  localparam int unsigned KeyMaxBytes = 256;
  // Number of non-ignored input beats the random part aims for.
  localparam int unsigned RandomBeats = 1950;
  // The final part of the run is driven without any idling on either side.
  localparam int unsigned QuietTail = 300;
  // The tail wait is long enough to cover one accepted key schedule.
  localparam int unsigned TailCycles = 1100;
  // Long receiver hold used to fill the block and push back on the input.
  localparam int unsigned LongHoldCycles = 64;
  // Cycles without any accepted beat before the run is declared hung. The worst
  // legal quiet stretch is one key schedule plus a long hold plus a few gaps.
  localparam int unsigned StallLimit = 4000;

  logic clk_i = 1'b0;
  logic rst_ni;

  rc4_in_if  in_if ();
  rc4_out_if out_if ();

  int unsigned pending_results;
  int unsigned mismatches;
  int unsigned cipher_beats;
  int unsigned keys_accepted;
  int unsigned keys_rejected;

  // Shared control between the input driver and the output receiver.
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned holds_done = 0;
  int unsigned beats_issued = 0;
  int unsigned longest_key = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  rc4_stream_cipher #(
    .KEY_MAX_BYTES(KeyMaxBytes)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  rc4_keystream_checker #(
    .KEY_MAX_BYTES(KeyMaxBytes)
  ) u_keystream_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .pending_o      (pending_results),
    .mismatches_o   (mismatches),
    .cipher_beats_o (cipher_beats),
    .keys_accepted_o(keys_accepted),
    .keys_rejected_o(keys_rejected)
  );

  // Offers one beat and returns at the edge where it is taken. Valid is left high,
  // so back-to-back beats stream without a bubble; the next call either replaces
  // the payload or drops valid for a short gap, never both in one step.
  task automatic send_beat(input logic kind, input logic [7:0] value, input logic mark_last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.kind          <= kind;
    in_if.byte_value    <= value;
    in_if.last_key_byte <= mark_last;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // A run of data beats. The last-key flag is random here, since the block must
  // ignore it on data.
  task automatic send_data_run(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_beat(KIND_DATA, 8'($urandom), 1'($urandom));
    end
    beats_issued += count;
  endtask

  // Sends key bytes. With reject set, the first byte is zero so the key is refused;
  // otherwise the first byte is forced nonzero. Only bytes the block can store count
  // toward the stimulus total.
  task automatic send_key(input int unsigned len, input bit reject, input bit close_key);
    logic [7:0] b;
    for (int unsigned n = 0; n < len; n++) begin
      b = 8'($urandom);
      if (n == 0) begin
        b = reject ? 8'h00 : ((b == 8'h00) ? 8'h01 : b);
      end
      send_beat(KIND_KEY, b, close_key && (n == len - 1));
    end
    beats_issued += (len > KeyMaxBytes) ? KeyMaxBytes : len;
    if (len > longest_key) begin
      longest_key = len;
    end
  endtask

  // Drops valid and holds the sender until every predicted result has come back.
  // The pending count from the checker is a registered value, so the first look is taken
  // at the edge after the last accepted beat.
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  function automatic int unsigned pick_key_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return KeyMaxBytes;
    end else if (r == 1) begin
      return $urandom_range(17, KeyMaxBytes - 1);
    end
    return $urandom_range(1, 16);
  endfunction

  // Receiver: random ready bursts, plus the long hold that the driver can request.
  // Each pass assigns ready once and then waits on the clock before the next pass.
  initial begin
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Watchdog: any accepted beat on either channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Timeout: no beat accepted for %0d cycles", StallLimit);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned head;

    in_if.valid         <= 1'b0;
    in_if.kind          <= KIND_KEY;
    in_if.byte_value    <= 8'h00;
    in_if.last_key_byte <= 1'b0;
    rst_ni              <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Data before any key runs on the identity permutation, and the
    // last-key flag on a data beat has no effect.
    send_beat(KIND_DATA, 8'h00, 1'b0);
    send_beat(KIND_DATA, 8'hFF, 1'b0);
    send_beat(KIND_DATA, 8'h5A, 1'b1);
    // A single zero byte is a refused key; the keystream must carry on unchanged.
    send_beat(KIND_KEY, 8'h00, 1'b1);
    send_beat(KIND_DATA, 8'h3C, 1'b0);
    // Shortest accepted key, with the top byte value.
    send_beat(KIND_KEY, 8'hFF, 1'b1);
    send_beat(KIND_DATA, 8'h00, 1'b0);
    send_beat(KIND_DATA, 8'hFF, 1'b0);
    // Data in the middle of a key uses the old state and keeps the partial key.
    send_beat(KIND_KEY, 8'h01, 1'b0);
    send_beat(KIND_DATA, 8'hA5, 1'b0);
    send_beat(KIND_KEY, 8'h80, 1'b1);
    send_beat(KIND_DATA, 8'h00, 1'b0);
    // A longer key that starts with zero is refused as well.
    send_beat(KIND_KEY, 8'h00, 1'b0);
    send_beat(KIND_KEY, 8'hFF, 1'b1);
    send_beat(KIND_DATA, 8'hFF, 1'b0);
    // Zero bytes after the first one are legal key content.
    send_beat(KIND_KEY, 8'h7F, 1'b0);
    send_beat(KIND_KEY, 8'h00, 1'b0);
    send_beat(KIND_KEY, 8'hFF, 1'b1);
    send_beat(KIND_DATA, 8'h01, 1'b1);
    send_beat(KIND_DATA, 8'h80, 1'b0);
    beats_issued = 0;

    // Backpressure: the receiver stops for a long stretch while data keeps coming,
    // then the sender waits for the block to drain completely.
    hold_req = 1'b1;
    send_data_run(24);
    wait_for_results();

    // A key longer than the store: bytes past the limit are dropped, the last
    // mark still closes it.
    send_key(KeyMaxBytes + 44, 1'b0, 1'b1);
    send_data_run($urandom_range(8, 20));

    // Random part. Most traffic is a key followed by a data run; the rest is refused
    // keys, keys split by data, over-long keys, holds, sender pauses and loose single beats.
    while (beats_issued < RandomBeats) begin
      if (beats_issued + QuietTail >= RandomBeats) begin
        idle_on = 1'b0;
      end else begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_key(pick_key_len(), 1'b0, 1'b1);
        send_data_run($urandom_range(4, 40));
      end else if (pick < 65) begin
        send_key($urandom_range(1, 8), 1'b1, 1'b1);
        send_data_run($urandom_range(2, 12));
      end else if (pick < 75) begin
        head = $urandom_range(1, 6);
        send_key(head, 1'b0, 1'b0);
        send_data_run($urandom_range(1, 6));
        send_key($urandom_range(1, 6), 1'b0, 1'b1);
        send_data_run($urandom_range(4, 20));
      end else if (pick < 80) begin
        send_key(KeyMaxBytes + $urandom_range(1, 40), 1'b0, 1'b1);
        send_data_run($urandom_range(4, 12));
      end else if (pick < 86 && idle_on) begin
        hold_req = 1'b1;
        send_data_run($urandom_range(16, 32));
      end else if (pick < 90) begin
        // Sender pause: nothing new until every result is back.
        wait_for_results();
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_beat(1'($urandom), 8'($urandom), 1'($urandom));
          beats_issued++;
        end
      end
    end

    wait_for_results();
    // Let a possible key schedule run out, so a stray late beat is still caught.
    repeat (TailCycles) @(posedge clk_i);

    $display("Checked %0d cipher beats and %0d key status beats (%0d accepted, %0d refused).",
             cipher_beats, keys_accepted + keys_rejected, keys_accepted, keys_rejected);
    $display("Keys up to %0d bytes, %0d long receiver holds, random idle bursts on both sides.",
             longest_key, holds_done);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
